@@ design/sgne_pkg.sv @@
// ----------------------------------------------------------------------------
// sgne_pkg
// Shared types and constants for the sphere grid neighbor enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgne_pkg;

  localparam int ROW_W         = 10;
  localparam int COL_W         = 11;
  localparam int LOG_W         = 4;
  localparam int CFG_W         = 11;
  localparam int MAX_ROWS      = 1024;
  localparam int MAX_LOG_COLS  = 11;
  localparam int MAX_NEIGHBORS = 64;
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS);
  localparam int POS_W         = COL_W + 2;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = CFG_W'(64);

  // Signed column position before wrapping into the target row.
  typedef logic signed [POS_W-1:0] pos_t;

  // Emission phase; the encoding is the neighbor_side code.
  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_ABOVE = 2'd1,
    PH_RIGHT = 2'd2,
    PH_BELOW = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_COUNT,
    ST_LEFT,
    ST_ABOVE,
    ST_RIGHT,
    ST_BELOW
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic   capture;
    logic   range;
    logic   count;
    logic   emit;
    phase_t phase;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic outside;
    logic top;
    logic bottom;
    logic above_end;
    logic last;
  } status_t;

endpackage

`default_nettype wire

@@ design/sgne_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgne_ctrl
// Sequencer: setup steps, then one emission phase after another.
// ----------------------------------------------------------------------------
`default_nettype none

module sgne_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  sgne_pkg::status_t  status,
  output logic               busy,
  output sgne_pkg::cmd_t     cmd
);

  sgne_pkg::state_t state;
  sgne_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sgne_pkg::ST_IDLE: begin
        if (start) state_next = sgne_pkg::ST_RANGE;
      end
      sgne_pkg::ST_RANGE: begin
        state_next = sgne_pkg::ST_COUNT;
      end
      sgne_pkg::ST_COUNT: begin
        // Pick the first phase that has entries.
        if (status.outside)     state_next = sgne_pkg::ST_IDLE;
        else if (status.top)    state_next = sgne_pkg::ST_BELOW;
        else if (status.bottom) state_next = sgne_pkg::ST_ABOVE;
        else                    state_next = sgne_pkg::ST_LEFT;
      end
      sgne_pkg::ST_LEFT: begin
        state_next = status.last ? sgne_pkg::ST_IDLE : sgne_pkg::ST_ABOVE;
      end
      sgne_pkg::ST_ABOVE: begin
        if (status.last)           state_next = sgne_pkg::ST_IDLE;
        else if (status.above_end) state_next = sgne_pkg::ST_RIGHT;
      end
      sgne_pkg::ST_RIGHT: begin
        state_next = status.last ? sgne_pkg::ST_IDLE : sgne_pkg::ST_BELOW;
      end
      sgne_pkg::ST_BELOW: begin
        if (status.last) state_next = sgne_pkg::ST_IDLE;
      end
      default: begin
        state_next = sgne_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state != sgne_pkg::ST_IDLE);
    cmd.capture = 1'b0;
    cmd.range   = 1'b0;
    cmd.count   = 1'b0;
    cmd.emit    = 1'b0;
    cmd.phase   = sgne_pkg::PH_LEFT;
    case (state)
      sgne_pkg::ST_IDLE:  cmd.capture = start;
      sgne_pkg::ST_RANGE: cmd.range = 1'b1;
      sgne_pkg::ST_COUNT: cmd.count = 1'b1;
      sgne_pkg::ST_LEFT: begin
        cmd.emit  = 1'b1;
        cmd.phase = sgne_pkg::PH_LEFT;
      end
      sgne_pkg::ST_ABOVE: begin
        cmd.emit  = 1'b1;
        cmd.phase = sgne_pkg::PH_ABOVE;
      end
      sgne_pkg::ST_RIGHT: begin
        cmd.emit  = 1'b1;
        cmd.phase = sgne_pkg::PH_RIGHT;
      end
      sgne_pkg::ST_BELOW: begin
        cmd.emit  = 1'b1;
        cmd.phase = sgne_pkg::PH_BELOW;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/sgne_datapath.sv @@
// ----------------------------------------------------------------------------
// sgne_datapath
// Cell registers, range computation, list length and the emission cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module sgne_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  sgne_pkg::cmd_t                      cmd,
  input  wire [sgne_pkg::CFG_W-1:0]           row_count,
  input  wire [sgne_pkg::ROW_W-1:0]           row_index,
  input  wire [sgne_pkg::COL_W-1:0]           col_index,
  input  wire [sgne_pkg::LOG_W-1:0]           above_size_log2,
  input  wire [sgne_pkg::LOG_W-1:0]           here_size_log2,
  input  wire [sgne_pkg::LOG_W-1:0]           below_size_log2,
  output sgne_pkg::status_t                   status,
  output logic                                neighbor_valid,
  output logic [sgne_pkg::ROW_W-1:0]          neighbor_row,
  output logic [sgne_pkg::COL_W-1:0]          neighbor_col,
  output logic [1:0]                          neighbor_side,
  output logic                                last_one,
  output logic                                truncated
);

  localparam int SPAN_W = sgne_pkg::POS_W + 1;

  typedef struct packed {
    sgne_pkg::pos_t from;
    sgne_pkg::pos_t to;
  } range_t;

  function automatic logic [sgne_pkg::LOG_W-1:0] sat_log(
    input logic [sgne_pkg::LOG_W-1:0] lg
  );
    logic [sgne_pkg::LOG_W-1:0] lim;
    lim = sgne_pkg::LOG_W'(sgne_pkg::MAX_LOG_COLS);
    return (lg > lim) ? lim : lg;
  endfunction

  function automatic logic [sgne_pkg::COL_W-1:0] col_mask(
    input logic [sgne_pkg::LOG_W-1:0] lg
  );
    return ~({sgne_pkg::COL_W{1'b1}} << lg);
  endfunction

  // Map a column of a row of size 2^src onto the matching span of a row of
  // size 2^tgt; on a shrink an exact half boundary takes both neighbors.
  function automatic range_t row_range(
    input logic [sgne_pkg::LOG_W-1:0] src,
    input logic [sgne_pkg::LOG_W-1:0] tgt,
    input logic [sgne_pkg::COL_W-1:0] c
  );
    logic [sgne_pkg::LOG_W-1:0] d;
    logic [sgne_pkg::COL_W:0]   half;
    logic [sgne_pkg::COL_W:0]   sum;
    logic [sgne_pkg::COL_W:0]   base;
    range_t                     rr;
    d    = '0;
    half = '0;
    sum  = '0;
    base = '0;
    if (tgt < src) begin
      d    = src - tgt;
      half = (sgne_pkg::COL_W+1)'(1) << (d - sgne_pkg::LOG_W'(1));
      if ((c & col_mask(d)) == half[sgne_pkg::COL_W-1:0]) begin
        rr.from = $signed({2'b00, c >> d});
        rr.to   = rr.from + sgne_pkg::POS_W'(1);
      end else begin
        sum     = {1'b0, c} + half;
        rr.from = $signed({1'b0, sum >> d});
        rr.to   = rr.from;
      end
    end else if (tgt > src) begin
      d       = tgt - src;
      half    = (sgne_pkg::COL_W+1)'(1) << (d - sgne_pkg::LOG_W'(1));
      base    = {1'b0, c} << d;
      rr.from = $signed({1'b0, base}) - $signed({1'b0, half});
      rr.to   = $signed({1'b0, base}) + $signed({1'b0, half});
    end else begin
      rr.from = $signed({2'b00, c}) - sgne_pkg::POS_W'(1);
      rr.to   = $signed({2'b00, c}) + sgne_pkg::POS_W'(1);
    end
    return rr;
  endfunction

  function automatic logic signed [SPAN_W-1:0] span(
    input sgne_pkg::pos_t from,
    input sgne_pkg::pos_t to
  );
    return $signed({to[sgne_pkg::POS_W-1], to}) -
           $signed({from[sgne_pkg::POS_W-1], from}) + SPAN_W'(1);
  endfunction

  // Cell registers.
  logic [sgne_pkg::ROW_W-1:0] r;
  logic [sgne_pkg::COL_W-1:0] c;
  logic [sgne_pkg::LOG_W-1:0] la;
  logic [sgne_pkg::LOG_W-1:0] lh;
  logic [sgne_pkg::LOG_W-1:0] lb;

  // Range registers.
  logic           outside;
  logic           top;
  logic           bottom;
  sgne_pkg::pos_t afrom;
  sgne_pkg::pos_t ato;
  sgne_pkg::pos_t bfrom;
  sgne_pkg::pos_t bto;

  // Emission registers.
  logic [sgne_pkg::CNT_W-1:0] last_idx;
  logic                       trunc;
  logic [sgne_pkg::CNT_W-1:0] emit_cnt;
  sgne_pkg::pos_t             cursor;

  logic [sgne_pkg::LOG_W-1:0]  lh_in;
  logic [sgne_pkg::CFG_W-1:0]  nrows;
  range_t                      ra;
  range_t                      rb;
  logic signed [SPAN_W-1:0]    total;
  logic                        total_trunc;
  logic [sgne_pkg::COL_W-1:0]  emit_col;
  logic [sgne_pkg::ROW_W-1:0]  emit_row;

  assign lh_in = sat_log(here_size_log2);

  always_comb begin
    nrows = row_count;
    if (row_count < sgne_pkg::CFG_W'(3)) begin
      nrows = sgne_pkg::CFG_W'(3);
    end else if (row_count > sgne_pkg::CFG_W'(sgne_pkg::MAX_ROWS)) begin
      nrows = sgne_pkg::CFG_W'(sgne_pkg::MAX_ROWS);
    end
    ra = row_range(lh, la, c);
    rb = row_range(lh, lb, c);
  end

  always_comb begin
    total = span(afrom, ato) + span(bfrom, bto);
    if (!top && !bottom) begin
      total = total + SPAN_W'(2);
    end
    total_trunc = (total > SPAN_W'(sgne_pkg::MAX_NEIGHBORS));
  end

  always_comb begin
    emit_row = r;
    emit_col = c;
    case (cmd.phase)
      sgne_pkg::PH_LEFT:  emit_col = (c - sgne_pkg::COL_W'(1)) & col_mask(lh);
      sgne_pkg::PH_RIGHT: emit_col = (c + sgne_pkg::COL_W'(1)) & col_mask(lh);
      sgne_pkg::PH_ABOVE: begin
        emit_row = r - sgne_pkg::ROW_W'(1);
        emit_col = cursor[sgne_pkg::COL_W-1:0] & col_mask(la);
      end
      sgne_pkg::PH_BELOW: begin
        emit_row = r + sgne_pkg::ROW_W'(1);
        emit_col = cursor[sgne_pkg::COL_W-1:0] & col_mask(lb);
      end
      default: emit_col = c;
    endcase
  end

  // Capture the cell; wrap the column into its own row at once.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r  <= row_index;
      c  <= col_index & col_mask(lh_in);
      la <= sat_log(above_size_log2);
      lh <= lh_in;
      lb <= sat_log(below_size_log2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range) begin
      outside <= ({1'b0, r} >= nrows);
      top     <= (r == '0);
      bottom  <= ({1'b0, r} == nrows - sgne_pkg::CFG_W'(1));
      if (r == '0) begin
        afrom <= '0;
        ato   <= '1;
        bfrom <= '0;
        bto   <= sgne_pkg::POS_W'(1) << lb;
      end else if ({1'b0, r} == nrows - sgne_pkg::CFG_W'(1)) begin
        afrom <= '0;
        ato   <= sgne_pkg::POS_W'(1) << la;
        bfrom <= '0;
        bto   <= '1;
      end else begin
        afrom <= ra.from;
        ato   <= ra.to;
        bfrom <= rb.from;
        bto   <= rb.to;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count) begin
      trunc    <= total_trunc;
      last_idx <= total_trunc ? {sgne_pkg::CNT_W{1'b1}}
                              : total[sgne_pkg::CNT_W-1:0] - sgne_pkg::CNT_W'(1);
      emit_cnt <= '0;
      cursor   <= top ? bto : afrom;
    end else if (cmd.emit) begin
      emit_cnt <= emit_cnt + sgne_pkg::CNT_W'(1);
      if (cmd.phase == sgne_pkg::PH_ABOVE) begin
        // Hand over to the below range after the last above entry.
        cursor <= (cursor == ato) ? bto : cursor + sgne_pkg::POS_W'(1);
      end else if (cmd.phase == sgne_pkg::PH_BELOW) begin
        cursor <= cursor - sgne_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_valid <= 1'b0;
    end else begin
      neighbor_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      neighbor_row  <= emit_row;
      neighbor_col  <= emit_col;
      neighbor_side <= cmd.phase;
      last_one      <= (emit_cnt == last_idx);
      truncated     <= trunc;
    end
  end

  assign status.outside   = outside;
  assign status.top       = top;
  assign status.bottom    = bottom;
  assign status.above_end = (cursor == ato);
  assign status.last      = (emit_cnt == last_idx);

endmodule

`default_nettype wire

@@ design/sphere_grid_neighbor_enumerator.sv @@
// ----------------------------------------------------------------------------
// sphere_grid_neighbor_enumerator
// Lists the neighbors of one cell of a latitude-row grid with power-of-two
// row sizes.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the cell fields and raise start; the cell transfers
//   at a rising edge with start high and busy low. busy stays high while the
//   cell is being worked on.
//   Result channel: each neighbor shows on the neighbor_* ports for exactly
//   one cycle with neighbor_valid high; the receiver cannot stall, so every
//   strobe is a transfer. Order: left, above-row range ascending, right,
//   below-row range descending. last_one marks the final entry; truncated is
//   set on every entry of a list cut at 64 entries.
//   Timing: setup steps (range, then list length) follow the transfer, then
//   one neighbor is emitted per cycle from the emission cursor. A row
//   outside the grid yields nothing.
//   Configuration: row_count is written through row_count_we/row_count_data;
//   the user must write it only while busy is low; the block does not
//   enforce this. Reset sets it to 64 and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_grid_neighbor_enumerator (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [sgne_pkg::ROW_W-1:0]    row_index,
  input  wire [sgne_pkg::COL_W-1:0]    col_index,
  input  wire [sgne_pkg::LOG_W-1:0]    above_size_log2,
  input  wire [sgne_pkg::LOG_W-1:0]    here_size_log2,
  input  wire [sgne_pkg::LOG_W-1:0]    below_size_log2,
  input  wire                          row_count_we,
  input  wire [sgne_pkg::CFG_W-1:0]    row_count_data,
  output logic                         neighbor_valid,
  output logic [sgne_pkg::ROW_W-1:0]   neighbor_row,
  output logic [sgne_pkg::COL_W-1:0]   neighbor_col,
  output logic [1:0]                   neighbor_side,
  output logic                         last_one,
  output logic                         truncated
);

  // Grid height register; clamped to the legal range where it is used.
  logic [sgne_pkg::CFG_W-1:0] row_count;

  sgne_pkg::cmd_t    cmd;
  sgne_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= sgne_pkg::ROW_COUNT_RESET;
    end else if (row_count_we) begin
      row_count <= row_count_data;
    end
  end

  // Sequencer: walks setup, then the left/above/right/below phases.
  sgne_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Datapath: ranges, list length, cursor and the result register.
  sgne_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .row_count       (row_count),
    .row_index       (row_index),
    .col_index       (col_index),
    .above_size_log2 (above_size_log2),
    .here_size_log2  (here_size_log2),
    .below_size_log2 (below_size_log2),
    .status          (status),
    .neighbor_valid  (neighbor_valid),
    .neighbor_row    (neighbor_row),
    .neighbor_col    (neighbor_col),
    .neighbor_side   (neighbor_side),
    .last_one        (last_one),
    .truncated       (truncated)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere grid neighbor enumerator. Cells are
// sent on the start/busy command port: first a short table of corner cases,
// then random cells over several row counts. Each neighbor strobe is
// checked field by field against a local model of the enumeration rules.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either side before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to let a cell with an empty list finish before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;
  localparam int CELLS_PER_PHASE = 17;
  localparam int DIR_ROWS = 21;

  // One neighbor as it shows on the result ports.
  typedef struct packed {
    logic [sgne_pkg::ROW_W-1:0] row;
    logic [sgne_pkg::COL_W-1:0] col;
    sgne_pkg::phase_t           side;
    logic                       last_one;
    logic                       truncated;
  } neighbor_t;

  // One cell to send. A typed_n of zero or more gives the list by hand:
  // typed_n copies of (t_row, t_col, t_side), last_one on the final copy.
  // A negative typed_n leaves the list to the local model.
  typedef struct packed {
    logic [sgne_pkg::ROW_W-1:0] row;
    logic [sgne_pkg::COL_W-1:0] col;
    logic [sgne_pkg::LOG_W-1:0] la;
    logic [sgne_pkg::LOG_W-1:0] lh;
    logic [sgne_pkg::LOG_W-1:0] lb;
    logic signed [7:0]          typed_n;
    logic [sgne_pkg::ROW_W-1:0] t_row;
    logic [sgne_pkg::COL_W-1:0] t_col;
    sgne_pkg::phase_t           t_side;
  } cell_row_t;

  // Corner cases, sent top to bottom, all with the reset row count of 64.
  localparam cell_row_t [DIR_ROWS-1:0] DIRECTED = '{
    // row outside the grid: nothing comes back
    '{10'd64,   11'd0,    4'd3,  4'd3,  4'd3,  8'sd0,  10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd1023, 11'd2047, 4'd15, 4'd15, 4'd15, 8'sd0,  10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // poles over a one-column row: column 0 twice
    '{10'd0,    11'd0,    4'd0,  4'd0,  4'd0,  8'sd2,  10'd1,  11'd0, sgne_pkg::PH_BELOW},
    '{10'd63,   11'd0,    4'd0,  4'd0,  4'd0,  8'sd2,  10'd62, 11'd0, sgne_pkg::PH_ABOVE},
    // equal sizes, tie on halving, plain halving, tie at a shift of one
    '{10'd5,    11'd3,    4'd3,  4'd3,  4'd3,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd7,    11'd2,    4'd2,  4'd4,  4'd4,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd7,    11'd5,    4'd2,  4'd4,  4'd6,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd8,    11'd1,    4'd0,  4'd1,  4'd2,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // left and right wrap around the row
    '{10'd9,    11'd0,    4'd3,  4'd3,  4'd3,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd9,    11'd7,    4'd3,  4'd3,  4'd3,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // widest rows, top column
    '{10'd10,   11'd2047, 4'd0,  4'd11, 4'd11, -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // widest expansion from a one-column row: list cut
    '{10'd11,   11'd0,    4'd11, 4'd0,  4'd11, -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // sizes above the maximum clamp
    '{10'd12,   11'd2047, 4'd15, 4'd15, 4'd15, -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // column beyond its row wraps first
    '{10'd13,   11'd2047, 4'd2,  4'd2,  4'd2,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // rows next to the poles
    '{10'd1,    11'd1,    4'd0,  4'd1,  4'd2,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd62,   11'd3,    4'd2,  4'd2,  4'd0,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // top pole: own column and row above play no part
    '{10'd0,    11'd5,    4'd7,  4'd3,  4'd5,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd0,    11'd0,    4'd0,  4'd0,  4'd11, -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // bottom pole: cut at full width and just past the limit
    '{10'd63,   11'd0,    4'd11, 4'd0,  4'd0,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    '{10'd63,   11'd9,    4'd6,  4'd2,  4'd9,  -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT},
    // halving with the top column bit set, no tie
    '{10'd20,   11'd1024, 4'd10, 4'd11, 4'd10, -8'sd1, 10'd0,  11'd0, sgne_pkg::PH_LEFT}
  };

  // Row counts for the random phases: below, at and above both clamps.
  localparam logic [PHASES-1:0][sgne_pkg::CFG_W-1:0] ROWS_PLAN = '{
    11'd3, 11'd1024, 11'd0, 11'd2047, 11'd2, 11'd1025, 11'd17, 11'd64
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [sgne_pkg::ROW_W-1:0] row_index = '0;
  logic [sgne_pkg::COL_W-1:0] col_index = '0;
  logic [sgne_pkg::LOG_W-1:0] above_size_log2 = '0;
  logic [sgne_pkg::LOG_W-1:0] here_size_log2 = '0;
  logic [sgne_pkg::LOG_W-1:0] below_size_log2 = '0;
  logic                       row_count_we = 1'b0;
  logic [sgne_pkg::CFG_W-1:0] row_count_data = '0;
  logic                       busy;
  logic                       neighbor_valid;
  logic [sgne_pkg::ROW_W-1:0] neighbor_row;
  logic [sgne_pkg::COL_W-1:0] neighbor_col;
  logic [1:0]                 neighbor_side;
  logic                       last_one;
  logic                       truncated;

  // Local copy of the row count register.
  logic [sgne_pkg::CFG_W-1:0] rows_cfg = sgne_pkg::ROW_COUNT_RESET;

  // Neighbors still owed by the block, oldest first.
  neighbor_t pending_neighbors[$];

  // Scratch list for one cell; staged_total keeps counting past the cut.
  neighbor_t staged[sgne_pkg::MAX_NEIGHBORS];
  int        staged_total;

  int mismatch_count = 0;
  int stall_cycles = 0;

  sphere_grid_neighbor_enumerator i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .row_index       (row_index),
    .col_index       (col_index),
    .above_size_log2 (above_size_log2),
    .here_size_log2  (here_size_log2),
    .below_size_log2 (below_size_log2),
    .row_count_we    (row_count_we),
    .row_count_data  (row_count_data),
    .neighbor_valid  (neighbor_valid),
    .neighbor_row    (neighbor_row),
    .neighbor_col    (neighbor_col),
    .neighbor_side   (neighbor_side),
    .last_one        (last_one),
    .truncated       (truncated)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model of the enumeration
  // --------------------------------------------------------------------------

  // Fold a column into a row of 2^lg columns; negatives wrap through
  // two's complement.
  function automatic logic [sgne_pkg::COL_W-1:0] wrap_to_row(input int v, input int lg);
    return sgne_pkg::COL_W'(v & ((1 << lg) - 1));
  endfunction

  // Column range in a row of 2^tgt columns seen from column c of a row of
  // 2^src columns. Shrinking rounds to nearest and takes both columns on an
  // exact half; growing spans half a step either side of the scaled column.
  function automatic void span_of(input int src, input int tgt, input int c,
                                  output int lo, output int hi);
    int d;
    int half;
    if (tgt < src) begin
      d = src - tgt;
      half = 1 << (d - 1);
      if ((c & ((1 << d) - 1)) == half) begin
        lo = c >> d;
        hi = lo + 1;
      end else begin
        lo = (c + half) >> d;
        hi = lo;
      end
    end else if (tgt > src) begin
      d = tgt - src;
      half = 1 << (d - 1);
      lo = (c << d) - half;
      hi = (c << d) + half;
    end else begin
      lo = c - 1;
      hi = c + 1;
    end
  endfunction

  // Append to the scratch list; past the limit only count.
  function automatic void stage_neighbor(input int r, input logic [sgne_pkg::COL_W-1:0] c,
                                         input sgne_pkg::phase_t side);
    if (staged_total < sgne_pkg::MAX_NEIGHBORS)
      staged[staged_total] = '{sgne_pkg::ROW_W'(r), c, side, 1'b0, 1'b0};
    staged_total++;
  endfunction

  function automatic int clamp_log(input logic [sgne_pkg::LOG_W-1:0] v);
    return (v > sgne_pkg::MAX_LOG_COLS) ? sgne_pkg::MAX_LOG_COLS : int'(v);
  endfunction

  function automatic int grid_rows();
    if (rows_cfg < 3)
      return 3;
    if (rows_cfg > sgne_pkg::MAX_ROWS)
      return sgne_pkg::MAX_ROWS;
    return int'(rows_cfg);
  endfunction

  // Work out the neighbor list of one cell and queue it.
  function automatic void enumerate_neighbors(input cell_row_t item);
    int  nrows, r, la, lh, lb, c, v, n;
    int  afrom, ato, bfrom, bto;
    bit  top, bottom, cut;
    nrows = grid_rows();
    r = int'(item.row);
    la = clamp_log(item.la);
    lh = clamp_log(item.lh);
    lb = clamp_log(item.lb);
    c = int'(item.col) & ((1 << lh) - 1);
    if (r >= nrows)
      return;
    top = (r == 0);
    bottom = (r == nrows - 1);
    afrom = 0;
    ato = -1;
    bfrom = 0;
    bto = -1;
    if (top) begin
      // whole row below, column 0 counted at both ends
      bto = 1 << lb;
    end else if (bottom) begin
      ato = 1 << la;
    end else begin
      span_of(lh, la, c, afrom, ato);
      span_of(lh, lb, c, bfrom, bto);
    end
    staged_total = 0;
    if (!top && !bottom)
      stage_neighbor(r, wrap_to_row(c - 1, lh), sgne_pkg::PH_LEFT);
    for (v = afrom; v <= ato; v++)
      stage_neighbor(r - 1, wrap_to_row(v, la), sgne_pkg::PH_ABOVE);
    if (!top && !bottom)
      stage_neighbor(r, wrap_to_row(c + 1, lh), sgne_pkg::PH_RIGHT);
    for (v = bto; v >= bfrom; v--)
      stage_neighbor(r + 1, wrap_to_row(v, lb), sgne_pkg::PH_BELOW);
    cut = (staged_total > sgne_pkg::MAX_NEIGHBORS);
    n = cut ? sgne_pkg::MAX_NEIGHBORS : staged_total;
    for (v = 0; v < n; v++) begin
      staged[v].truncated = cut;
      staged[v].last_one = (v == n - 1);
      pending_neighbors.push_back(staged[v]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 95)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Row sizes lean small so most lists stay short; a few hit the clamp.
  function automatic logic [sgne_pkg::LOG_W-1:0] pick_log();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80)
      return sgne_pkg::LOG_W'($urandom_range(0, 5));
    if (roll < 95)
      return sgne_pkg::LOG_W'($urandom_range(6, 11));
    return sgne_pkg::LOG_W'($urandom_range(12, 15));
  endfunction

  // Neighboring rows usually differ from the cell's own row by a step or two.
  function automatic logic [sgne_pkg::LOG_W-1:0] pick_near(
    input logic [sgne_pkg::LOG_W-1:0] lh
  );
    int v;
    if ($urandom_range(0, 9) < 3)
      return sgne_pkg::LOG_W'($urandom_range(0, 15));
    v = int'(lh) + $urandom_range(0, 4) - 2;
    if (v < 0)
      v = 0;
    if (v > 15)
      v = 15;
    return sgne_pkg::LOG_W'(v);
  endfunction

  function automatic cell_row_t random_cell();
    cell_row_t item;
    int        nrows, kind;
    nrows = grid_rows();
    kind = $urandom_range(0, 19);
    item = '0;
    item.typed_n = -8'sd1;
    if (kind < 2)
      // outside the grid where the grid allows it, else anywhere
      item.row = sgne_pkg::ROW_W'((nrows < sgne_pkg::MAX_ROWS)
                                  ? $urandom_range(nrows, sgne_pkg::MAX_ROWS - 1)
                                  : $urandom_range(0, sgne_pkg::MAX_ROWS - 1));
    else if (kind < 4)
      item.row = '0;
    else if (kind < 6)
      item.row = sgne_pkg::ROW_W'(nrows - 1);
    else
      item.row = sgne_pkg::ROW_W'($urandom_range(1, nrows - 2));
    item.col = sgne_pkg::COL_W'($urandom_range(0, 2047));
    item.lh = pick_log();
    item.la = pick_near(item.lh);
    item.lb = pick_near(item.lh);
    return item;
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Present one cell and hold it until the transfer, then queue its list.
  // With a zero gap start stays high for the next cell.
  task automatic send_cell(input cell_row_t item, input int gap);
    int k;
    row_index       <= item.row;
    col_index       <= item.col;
    above_size_log2 <= item.la;
    here_size_log2  <= item.lh;
    below_size_log2 <= item.lb;
    start           <= 1'b1;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    if (item.typed_n < 0) begin
      enumerate_neighbors(item);
    end else begin
      for (k = 0; k < item.typed_n; k++)
        pending_neighbors.push_back('{item.t_row, item.t_col, item.t_side,
                                      k == item.typed_n - 1, 1'b0});
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every owed neighbor has come and the block is
  // quiet, then let a cell with an empty list run out.
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_neighbors.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_count(input logic [sgne_pkg::CFG_W-1:0] value);
    drain_block();
    row_count_we   <= 1'b1;
    row_count_data <= value;
    @(posedge clk);
    row_count_we   <= 1'b0;
    rows_cfg = value;
  endtask

  // --------------------------------------------------------------------------
  // Result side: every strobe is a transfer; match it to the oldest entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    neighbor_t want;
    if (!rst && neighbor_valid) begin
      if (pending_neighbors.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected neighbor: expected none, actual row %0d col %0d side %0d",
                 $time, neighbor_row, neighbor_col, neighbor_side);
      end else begin
        want = pending_neighbors.pop_front();
        if (neighbor_row !== want.row) begin
          mismatch_count++;
          $display("%0t: neighbor_row expected %0d actual %0d",
                   $time, want.row, neighbor_row);
        end
        if (neighbor_col !== want.col) begin
          mismatch_count++;
          $display("%0t: neighbor_col expected %0d actual %0d",
                   $time, want.col, neighbor_col);
        end
        if (neighbor_side !== want.side) begin
          mismatch_count++;
          $display("%0t: neighbor_side expected %0d actual %0d",
                   $time, want.side, neighbor_side);
        end
        if (last_one !== want.last_one) begin
          mismatch_count++;
          $display("%0t: last_one expected %0d actual %0d",
                   $time, want.last_one, last_one);
        end
        if (truncated !== want.truncated) begin
          mismatch_count++;
          $display("%0t: truncated expected %0d actual %0d",
                   $time, want.truncated, truncated);
        end
      end
    end
  end

  // Watchdog: restart on any transfer, give up after a long silence.
  always @(posedge clk) begin
    if (rst || (start && !busy) || neighbor_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit steady;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner cases at the reset row count.
    for (int i = DIR_ROWS - 1; i >= 0; i--)
      send_cell(DIRECTED[i], pick_gap(1'b0));

    // Random cells, one row count per phase; every third phase runs with
    // no gaps, the others hold off now and then until the block drains.
    for (int p = PHASES - 1; p >= 0; p--) begin
      write_row_count(ROWS_PLAN[p]);
      steady = (p % 3 == 1);
      for (int i = 0; i < CELLS_PER_PHASE; i++) begin
        if (!steady && $urandom_range(0, 11) == 0)
          drain_block();
        send_cell(random_cell(), pick_gap(steady));
      end
    end

    drain_block();
    if (mismatch_count == 0 && pending_neighbors.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
